[src/sebfr_pkg.sv]
// shared constants and control/status types of the stx/etx bcc frame receiver
`default_nettype none

package sebfr_pkg;

	localparam int          FRAME_DEPTH_DEF = 64;
	localparam int          LIMIT_W         = 6;
	localparam logic [5:0]  LIMIT_RESET     = 6'd58;
	localparam logic [7:0]  CHR_STX         = 8'h02;
	localparam logic [7:0]  CHR_ETX         = 8'h03;

	typedef struct packed {
		logic start;
		logic put;
		logic len_h_ld;
		logic len_l_ld;
		logic data_inc;
		logic rd_start;
		logic rd_next;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_stx;
		logic is_etx;
		logic bcc_ok;
		logic len_zero;
		logic len_over;
		logic data_last;
		logic rd_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[src/stx_etx_bcc_frame_receiver.sv]
// top level of the stx/etx frame receiver with xor bcc check
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------
//  input    | in_valid / in_stall           | rx_byte[7:0]
//  output   | out_valid / out_stall         | frame_byte[7:0], last_byte
//  config   | cfg_wr_en                     | cfg_wr_data[5:0] (length_limit)
//
// while parsing, one input transaction is taken every cycle
// an accepted frame is replayed from the frame store, one store read and one
// output register load per byte; input stalls meanwhile
// a byte waits to load while the output register is stalled
// arst_n clears control state and sets length_limit to 58; the store needs no clearing
`default_nettype none

module stx_etx_bcc_frame_receiver #(
	parameter int FRAME_DEPTH = sebfr_pkg::FRAME_DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [sebfr_pkg::LIMIT_W-1:0] cfg_wr_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [7:0]                    rx_byte,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [7:0]                   frame_byte,
	output logic                         last_byte
);
	import sebfr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sebfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sebfr_datapath #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

	a_load_only_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> in_stall)
		else $error("output load outside of replay");

	a_start_on_stx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (in_valid && !in_stall && rx_byte == CHR_STX))
		else $error("frame start without accepted stx");

	a_replay_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_start |=> in_stall)
		else $error("input not stalled after frame accepted");

endmodule

`default_nettype wire

[src/sebfr_ctrl.sv]
// parser and replay controller state machine
`default_nettype none

module sebfr_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  sebfr_pkg::sts_t   sts,
	output sebfr_pkg::cmd_t   cmd
);
	import sebfr_pkg::*;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_CMD,
		ST_LEN_H,
		ST_LEN_L,
		ST_DATA,
		ST_ETX,
		ST_BCC,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;

	assign in_stall = (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_WR);
	assign acc      = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_HUNT: begin
				if (acc && sts.is_stx) begin
					cmd.start = 1'b1;
					state_d   = ST_CMD;
				end
			end
			ST_CMD: begin
				if (acc) begin
					cmd.put = 1'b1;
					state_d = ST_LEN_H;
				end
			end
			ST_LEN_H: begin
				if (acc) begin
					cmd.put      = 1'b1;
					cmd.len_h_ld = 1'b1;
					state_d      = ST_LEN_L;
				end
			end
			ST_LEN_L: begin
				if (acc) begin
					cmd.put      = 1'b1;
					cmd.len_l_ld = 1'b1;
					if (sts.len_zero) begin
						state_d = ST_ETX;
					end else if (sts.len_over) begin
						state_d = ST_HUNT;
					end else begin
						state_d = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (acc) begin
					cmd.put      = 1'b1;
					cmd.data_inc = 1'b1;
					if (sts.data_last) begin
						state_d = ST_ETX;
					end
				end
			end
			ST_ETX: begin
				if (acc) begin
					if (sts.is_etx) begin
						cmd.put = 1'b1;
						state_d = ST_BCC;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_BCC: begin
				if (acc) begin
					if (sts.bcc_ok) begin
						cmd.put      = 1'b1;
						cmd.rd_start = 1'b1;
						state_d      = ST_EMIT_RD;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.rd_next  = 1'b1;
					state_d      = sts.rd_last ? ST_HUNT : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[src/sebfr_datapath.sv]
// frame store, length and bcc tracking, replay read and output register
`default_nettype none

module sebfr_datapath #(
	parameter int FRAME_DEPTH = sebfr_pkg::FRAME_DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wr_en,
	input  wire [sebfr_pkg::LIMIT_W-1:0]    cfg_wr_data,
	input  wire [7:0]                       rx_byte,
	input  sebfr_pkg::cmd_t                 cmd,
	output sebfr_pkg::sts_t                 sts,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [7:0]                      frame_byte,
	output logic                            last_byte
);
	import sebfr_pkg::*;

	localparam int AW  = $clog2(FRAME_DEPTH);
	localparam int IW  = $clog2(FRAME_DEPTH + 1);
	localparam int CAP = FRAME_DEPTH - 6;

	logic [7:0]         mem [FRAME_DEPTH];
	logic [LIMIT_W-1:0] limit_q;
	logic [IW-1:0]      wr_idx_q;
	logic [IW-1:0]      rd_ptr_q;
	logic [IW-1:0]      len_q;
	logic [IW-1:0]      data_cnt_q;
	logic [7:0]         len_h_q;
	logic [7:0]         bcc_q;
	logic [7:0]         rd_q;
	logic               out_valid_q;
	logic [7:0]         frame_byte_q;
	logic               last_q;
	logic [15:0]        len_full;
	logic [15:0]        eff_limit;
	logic [AW-1:0]      wr_addr;

	assign len_full  = {len_h_q, rx_byte};
	assign eff_limit = (16'(limit_q) < 16'(CAP)) ? 16'(limit_q) : 16'(CAP);
	assign wr_addr   = cmd.start ? '0 : wr_idx_q[AW-1:0];

	assign sts.is_stx    = (rx_byte == CHR_STX);
	assign sts.is_etx    = (rx_byte == CHR_ETX);
	assign sts.bcc_ok    = (rx_byte == bcc_q);
	assign sts.len_zero  = (len_full == 16'd0);
	assign sts.len_over  = (len_full > eff_limit);
	assign sts.data_last = ((data_cnt_q + IW'(1)) == len_q);
	assign sts.rd_last   = ((rd_ptr_q + IW'(1)) == wr_idx_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_q;

	always_ff @(posedge clk) begin
		if (cmd.start || cmd.put) begin
			mem[wr_addr] <= rx_byte;
		end
		rd_q <= mem[rd_ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			wr_idx_q    <= '0;
			rd_ptr_q    <= '0;
			len_q       <= '0;
			data_cnt_q  <= '0;
			len_h_q     <= '0;
			bcc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd.start) begin
				wr_idx_q   <= IW'(1);
				bcc_q      <= rx_byte;
				data_cnt_q <= '0;
			end else if (cmd.put) begin
				wr_idx_q <= wr_idx_q + IW'(1);
				bcc_q    <= bcc_q ^ rx_byte;
			end
			if (cmd.len_h_ld) begin
				len_h_q <= rx_byte;
			end
			if (cmd.len_l_ld) begin
				len_q <= rx_byte[IW-1:0];
			end
			if (cmd.data_inc) begin
				data_cnt_q <= data_cnt_q + IW'(1);
			end
			if (cmd.rd_start) begin
				rd_ptr_q <= '0;
			end else if (cmd.rd_next) begin
				rd_ptr_q <= rd_ptr_q + IW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			frame_byte_q <= rd_q;
			last_q       <= sts.rd_last;
		end
	end

endmodule

`default_nettype wire

[test/tb_stx_etx_bcc_frame_receiver.sv]
// self-checking testbench of the stx/etx frame receiver with xor bcc check
`default_nettype none

module tb_stx_etx_bcc_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import sebfr_pkg::*;

	localparam int LIMIT_CAP   = FRAME_DEPTH_DEF - 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [2:0] {
		P_HUNT, P_CMD, P_LEN_H, P_LEN_L, P_DATA, P_ETX, P_BCC
	} parse_e;

	typedef enum logic [1:0] {V_PRED, V_ECHO, V_DROP} verdict_e;

	typedef struct packed {
		logic [7:0] fb;
		logic       lb;
	} echo_t;

	typedef struct packed {
		logic [7:0]  cmd;
		logic [15:0] len;
		logic [7:0]  fill;
		logic [7:0]  etx;
		logic [7:0]  bcc_mask;
		verdict_e    verdict;
	} row_t;

	localparam row_t ROWS [7] = '{
		'{8'h00, 16'h0000, 8'h00, CHR_ETX, 8'h00, V_ECHO},
		'{8'hFF, 16'h0001, 8'hFF, CHR_ETX, 8'h00, V_ECHO},
		'{8'h11, 16'h003B, 8'h00, CHR_ETX, 8'h00, V_DROP},
		'{8'h13, 16'hFFFF, 8'h00, CHR_ETX, 8'h00, V_DROP},
		'{8'h20, 16'h0001, 8'h7E, CHR_STX, 8'h00, V_DROP},
		'{8'h01, 16'h0000, 8'h00, CHR_ETX, 8'h02, V_DROP},
		'{CHR_STX, 16'h0002, CHR_STX, CHR_ETX, 8'h00, V_PRED}
	};

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [LIMIT_W-1:0] cfg_wr_data = '0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	logic [7:0]       rx_byte     = 8'h00;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic [7:0]       frame_byte;
	logic             last_byte;

	// receiver model state
	parse_e      ps;
	logic [7:0]  store_mem [FRAME_DEPTH_DEF];
	int          wr_idx;
	logic [15:0] exp_len;
	logic [15:0] dcount;
	logic [7:0]  bcc;
	logic [5:0]  lim;

	echo_t pending_bytes [$];
	echo_t want;
	bit    hand_checked = 1'b0;
	int    errors       = 0;
	int    cycles       = 0;
	int    frame_bytes  = 0;
	int    idle_pct     = 0;
	int    stall_pct    = 0;
	bit    hold_req     = 1'b0;
	int    hold_left    = 0;

	stx_etx_bcc_frame_receiver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

	always #4 clk = ~clk;

	function automatic int eff_limit();
		return (int'(lim) < LIMIT_CAP) ? int'(lim) : LIMIT_CAP;
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (wr_idx < FRAME_DEPTH_DEF) begin
			store_mem[wr_idx] = b;
			wr_idx++;
		end
		bcc ^= b;
	endfunction

	function automatic void parse_rx(input logic [7:0] b);
		int i;
		case (ps)
			P_HUNT: begin
				wr_idx = 0;
				dcount = '0;
				bcc = '0;
				if (b == CHR_STX) begin
					store_byte(b);
					ps = P_CMD;
				end
			end
			P_CMD: begin
				store_byte(b);
				ps = P_LEN_H;
			end
			P_LEN_H: begin
				store_byte(b);
				exp_len = {b, 8'h00};
				ps = P_LEN_L;
			end
			P_LEN_L: begin
				store_byte(b);
				exp_len[7:0] = b;
				if (exp_len == 16'h0000)
					ps = P_ETX;
				else if (int'(exp_len) > eff_limit())
					ps = P_HUNT;
				else
					ps = P_DATA;
			end
			P_DATA: begin
				dcount++;
				store_byte(b);
				if (dcount >= exp_len)
					ps = P_ETX;
			end
			P_ETX: begin
				if (b == CHR_ETX) begin
					store_byte(b);
					ps = P_BCC;
				end else begin
					ps = P_HUNT;
				end
			end
			P_BCC: begin
				ps = P_HUNT;
				if (b == bcc && wr_idx < FRAME_DEPTH_DEF) begin
					store_mem[wr_idx] = b;
					wr_idx++;
					if (!hand_checked)
						for (i = 0; i < wr_idx; i++)
							pending_bytes.push_back('{store_mem[i], i == wr_idx - 1});
				end
			end
			default: ps = P_HUNT;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		parse_rx(b);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
			input logic [7:0] fill, input bit rnd, input logic [7:0] etx,
			input logic [7:0] bcc_mask, input verdict_e v);
		logic [7:0] fr [$];
		logic [7:0] sum;
		int i;
		fr = '{CHR_STX, cmd, len[15:8], len[7:0]};
		if (int'(len) <= eff_limit()) begin
			for (i = 0; i < int'(len); i++)
				fr.push_back(rnd ? 8'($urandom) : 8'(fill + i));
			fr.push_back(etx);
			if (etx == CHR_ETX) begin
				sum = 8'h00;
				foreach (fr[j])
					sum ^= fr[j];
				fr.push_back(sum ^ bcc_mask);
			end
		end
		hand_checked = (v != V_PRED);
		for (i = 0; i < fr.size(); i++) begin
			if (v == V_ECHO && i == fr.size() - 1)
				foreach (fr[j])
					pending_bytes.push_back('{fr[j], j == fr.size() - 1});
			send_byte(fr[i]);
		end
		hand_checked = 1'b0;
		frame_bytes += fr.size();
	endtask

	task automatic random_frame();
		int r;
		int top;
		logic [15:0] len;
		logic [7:0] etx;
		logic [7:0] mask;
		r = $urandom_range(99);
		top = eff_limit();
		if ($urandom_range(99) < 80)
			len = 16'($urandom_range(0, (top < 6) ? top : 6));
		else
			len = 16'($urandom_range(0, top));
		etx = CHR_ETX;
		mask = 8'h00;
		if (r < 8) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		end else begin
			if (r < 18) begin
				if ($urandom_range(1))
					len = 16'(top + 1);
				else
					len = 16'($urandom_range(top + 1, 16'hFFFF));
			end else if (r < 26) begin
				do etx = 8'($urandom); while (etx == CHR_ETX);
			end else if (r < 34) begin
				mask = 8'($urandom_range(1, 255));
			end
			send_frame(8'($urandom), len, 8'h00, 1'b1, etx, mask, V_PRED);
		end
	endtask

	task automatic start_phase(input logic [5:0] v, input int idle, input int stall,
			input bit hold);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		lim = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		idle_pct = idle;
		stall_pct = stall;
		hold_req = hold;
		@(negedge clk);
	endtask

	// bring the parser back to hunting, then let every frame drain
	task automatic finish_phase();
		while (ps != P_HUNT)
			send_byte(8'h00);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected transaction frame_byte %02h last_byte %0b",
					$time, frame_byte, last_byte);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (frame_byte !== want.fb) begin
					$display("%0t: frame_byte expected %02h actual %02h",
						$time, want.fb, frame_byte);
					errors++;
				end
				if (last_byte !== want.lb) begin
					$display("%0t: last_byte expected %0b actual %0b",
						$time, want.lb, last_byte);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL stx_etx_bcc_frame_receiver");
			$finish;
		end
	end

	initial begin
		int p;
		int goal;
		ps = P_HUNT;
		wr_idx = 0;
		exp_len = '0;
		dcount = '0;
		bcc = '0;
		lim = LIMIT_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (ROWS[k])
			send_frame(ROWS[k].cmd, ROWS[k].len, ROWS[k].fill, 1'b0, ROWS[k].etx,
				ROWS[k].bcc_mask, ROWS[k].verdict);
		finish_phase();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: start_phase(LIMIT_RESET, 0, 0, 1'b0);
				1: start_phase(6'd0, 65, 0, 1'b0);
				2: start_phase(6'd63, 0, 65, 1'b0);
				3: start_phase(6'd1, 35, 35, 1'b0);
				4: start_phase(6'($urandom_range(2, 57)), 0, 0, 1'b1);
				default: start_phase(6'($urandom_range(0, 63)), 35, 35, 1'b0);
			endcase
			if (p == 2)
				send_frame(8'($urandom), 16'd59, 8'h00, 1'b1, CHR_ETX, 8'h00, V_PRED);
			if (p == 4)
				send_frame(8'($urandom), 16'd2, 8'h00, 1'b1, CHR_ETX, 8'h00, V_PRED);
			goal = frame_bytes + 8;
			while (frame_bytes < goal)
				random_frame();
			finish_phase();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS stx_etx_bcc_frame_receiver");
		else
			$display("FAIL stx_etx_bcc_frame_receiver");
		$finish;
	end

endmodule

`default_nettype wire

[stx_etx_bcc_frame_receiver.f]
src/sebfr_pkg.sv
src/sebfr_ctrl.sv
src/sebfr_datapath.sv
src/stx_etx_bcc_frame_receiver.sv
test/tb_stx_etx_bcc_frame_receiver.sv
